[rtl/hdist_pkg.sv]
// Shared constants, types and the CORDIC angle table for the haversine distance pipeline.
package hdist_pkg;

	typedef logic [30:0] q30_t;

	localparam int CORDIC_STAGES = 20;
	localparam int ISQRT_STAGES  = 31;

	localparam logic signed [23:0] LAT_MAX = 24'sd5898240;
	localparam logic signed [23:0] LAT_MIN = -24'sd5898240;
	localparam logic signed [24:0] LON_MAX = 25'sd11796480;
	localparam logic signed [24:0] LON_MIN = -25'sd11796480;

	localparam logic [23:0] DEG90_Q16  = 24'd5898240;
	localparam logic [24:0] DEG180_Q16 = 25'd11796480;

	localparam q30_t        ONE_Q30          = 31'd1073741824;
	localparam logic [32:0] CORDIC_INV_GAIN  = 33'd652032875;
	localparam logic [30:0] DEG_TO_KM256_Q16 = 31'd1865538680;

	// CORDIC elementary angles, degrees Q16
	function automatic logic signed [25:0] atan_deg(input int i);
		logic signed [25:0] r;
		begin
			case (i)
				0:  r = 26'sd2949120;
				1:  r = 26'sd1740967;
				2:  r = 26'sd919879;
				3:  r = 26'sd466945;
				4:  r = 26'sd234379;
				5:  r = 26'sd117266;
				6:  r = 26'sd58666;
				7:  r = 26'sd29335;
				8:  r = 26'sd14668;
				9:  r = 26'sd7334;
				10: r = 26'sd3667;
				11: r = 26'sd1833;
				12: r = 26'sd917;
				13: r = 26'sd458;
				14: r = 26'sd229;
				15: r = 26'sd115;
				16: r = 26'sd57;
				17: r = 26'sd29;
				18: r = 26'sd14;
				19: r = 26'sd7;
				default: r = 26'sd0;
			endcase
			return r;
		end
	endfunction

	// Clamp a signed value into [0, 1.0] in Q30
	function automatic q30_t clamp_q30(input logic signed [33:0] v);
		q30_t r;
		begin
			if (v[33])
				r = '0;
			else if (v > $signed({3'b000, ONE_Q30}))
				r = ONE_Q30;
			else
				r = v[30:0];
			return r;
		end
	endfunction

endpackage

[rtl/hdist_cordic_rot.sv]
// Pipelined CORDIC rotation: cosine and sine magnitudes of an angle in degrees Q16.
module hdist_cordic_rot (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic signed [25:0]  ang,
	output logic                out_valid,
	output hdist_pkg::q30_t     cos_mag,
	output hdist_pkg::q30_t     sin_mag
);

	localparam int N = hdist_pkg::CORDIC_STAGES;

	logic signed [32:0] px [N];
	logic signed [32:0] py [N];
	logic signed [25:0] pz [N];
	logic signed [32:0] x_sn [N];
	logic signed [32:0] y_sn [N];
	logic signed [25:0] z_sn [N];
	logic [N-1:0]       v_sn;
	logic signed [32:0] y_abs;
	logic               valid_q;
	hdist_pkg::q30_t    cos_q;
	hdist_pkg::q30_t    sin_q;

	// Feed each stage from the one before it
	always_comb begin
		px[0] = $signed(hdist_pkg::CORDIC_INV_GAIN);
		py[0] = '0;
		pz[0] = ang;
		for (int i = 1; i < N; i++) begin
			px[i] = x_sn[i-1];
			py[i] = y_sn[i-1];
			pz[i] = z_sn[i-1];
		end
	end

	// Rotate one step per stage towards zero residual angle
	always_ff @(posedge clk) begin
		for (int i = 0; i < N; i++) begin
			if (!pz[i][25]) begin
				x_sn[i] <= px[i] - (py[i] >>> i);
				y_sn[i] <= py[i] + (px[i] >>> i);
				z_sn[i] <= pz[i] - hdist_pkg::atan_deg(i);
			end else begin
				x_sn[i] <= px[i] + (py[i] >>> i);
				y_sn[i] <= py[i] - (px[i] >>> i);
				z_sn[i] <= pz[i] + hdist_pkg::atan_deg(i);
			end
		end
	end

	// Advance valid bits alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sn    <= '0;
			valid_q <= 1'b0;
		end else begin
			v_sn    <= {v_sn[N-2:0], in_valid};
			valid_q <= v_sn[N-1];
		end
	end

	assign y_abs = y_sn[N-1][32] ? -y_sn[N-1] : y_sn[N-1];

	// Clamp the magnitudes into [0, 1.0]
	always_ff @(posedge clk) begin
		cos_q <= hdist_pkg::clamp_q30(34'(x_sn[N-1]));
		sin_q <= hdist_pkg::clamp_q30(34'(y_abs));
	end

	assign out_valid = valid_q;
	assign cos_mag   = cos_q;
	assign sin_mag   = sin_q;

endmodule

[rtl/hdist_isqrt.sv]
// Pipelined integer floor square root, one result bit per stage.
module hdist_isqrt (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [60:0]      arg,
	output logic             out_valid,
	output hdist_pkg::q30_t  root
);

	localparam int N = hdist_pkg::ISQRT_STAGES;

	logic [60:0] pv [N];
	logic [61:0] pr [N];
	logic [60:0] v_rem_sn [N];
	logic [61:0] r_sn [N];
	logic [N-1:0] v_sn;

	// Feed each stage from the one before it
	always_comb begin
		pv[0] = arg;
		pr[0] = '0;
		for (int j = 1; j < N; j++) begin
			pv[j] = v_rem_sn[j-1];
			pr[j] = r_sn[j-1];
		end
	end

	// Try one result bit per stage, most significant first
	always_ff @(posedge clk) begin
		for (int j = 0; j < N; j++) begin
			if ({1'b0, pv[j]} >= pr[j] + (62'd1 << (2 * (N - 1 - j)))) begin
				v_rem_sn[j] <= pv[j] - 61'(pr[j] + (62'd1 << (2 * (N - 1 - j))));
				r_sn[j]     <= (pr[j] >> 1) + (62'd1 << (2 * (N - 1 - j)));
			end else begin
				v_rem_sn[j] <= pv[j];
				r_sn[j]     <= pr[j] >> 1;
			end
		end
	end

	// Advance valid bits alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_sn <= '0;
		else
			v_sn <= {v_sn[N-2:0], in_valid};
	end

	assign out_valid = v_sn[N-1];
	assign root      = r_sn[N-1][30:0];

endmodule

[rtl/hdist_cordic_vec.sv]
// Pipelined CORDIC vectoring: atan2(p, q) in degrees Q16, clamped to [0, 90].
module hdist_cordic_vec (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  hdist_pkg::q30_t  p,
	input  hdist_pkg::q30_t  q,
	output logic             out_valid,
	output logic [22:0]      angle
);

	localparam int N = hdist_pkg::CORDIC_STAGES;

	logic signed [33:0] px [N];
	logic signed [33:0] py [N];
	logic signed [25:0] pz [N];
	logic signed [33:0] x_sn [N];
	logic signed [33:0] y_sn [N];
	logic signed [25:0] z_sn [N];
	logic [N-1:0]       v_sn;
	logic               valid_q;
	logic [22:0]        angle_q;

	// Feed each stage from the one before it
	always_comb begin
		px[0] = $signed({3'b000, q});
		py[0] = $signed({3'b000, p});
		pz[0] = '0;
		for (int i = 1; i < N; i++) begin
			px[i] = x_sn[i-1];
			py[i] = y_sn[i-1];
			pz[i] = z_sn[i-1];
		end
	end

	// Drive y towards zero and sum the angles turned through
	always_ff @(posedge clk) begin
		for (int i = 0; i < N; i++) begin
			if (!py[i][33] && (py[i] != '0)) begin
				x_sn[i] <= px[i] + (py[i] >>> i);
				y_sn[i] <= py[i] - (px[i] >>> i);
				z_sn[i] <= pz[i] + hdist_pkg::atan_deg(i);
			end else begin
				x_sn[i] <= px[i] - (py[i] >>> i);
				y_sn[i] <= py[i] + (px[i] >>> i);
				z_sn[i] <= pz[i] - hdist_pkg::atan_deg(i);
			end
		end
	end

	// Advance valid bits alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sn    <= '0;
			valid_q <= 1'b0;
		end else begin
			v_sn    <= {v_sn[N-2:0], in_valid};
			valid_q <= v_sn[N-1];
		end
	end

	// Clamp the angle into [0, 90 degrees]
	always_ff @(posedge clk) begin
		if (z_sn[N-1][25])
			angle_q <= '0;
		else if (z_sn[N-1] > $signed({2'b00, hdist_pkg::DEG90_Q16}))
			angle_q <= hdist_pkg::DEG90_Q16[22:0];
		else
			angle_q <= z_sn[N-1][22:0];
	end

	assign out_valid = valid_q;
	assign angle     = angle_q;

endmodule

[rtl/haversine_distance_top.sv]
// Haversine great-circle distance: a fully pipelined datapath taking one request per cycle.
// Throughput: one request every cycle; busy stays low, set by the unrolled CORDIC
// and square-root stages, each handling a new request every cycle.
// Results show on distance_km for one cycle with done; the receiver cannot stall.
// Reset (arst_n low) clears all valid bits at once; requests in flight are dropped.
module haversine_distance_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [23:0] lat_a,
	input  logic signed [24:0] lon_a,
	input  logic signed [23:0] lat_b,
	input  logic signed [24:0] lon_b,
	output logic               done,
	output logic [22:0]        distance_km
);

	logic signed [23:0] la_s1, lb_s1;
	logic signed [24:0] oa_s1, ob_s1;
	logic               v_s1;
	logic signed [23:0] la_s2, lb_s2;
	logic [23:0]        hlat_s2, hlon_s2;
	logic               v_s2;

	logic signed [24:0] dlat;
	logic signed [25:0] dlon;
	logic [24:0]        dlat_mag;
	logic [25:0]        dlon_mag;
	logic [24:0]        hlon_raw;

	logic               rot_valid;
	hdist_pkg::q30_t    s_lat, s_lon, c_a, c_b;
	hdist_pkg::q30_t    unused_c0, unused_c1, unused_s0, unused_s1;

	logic [61:0]        slat_sq, slon_sq, cacb, term;
	hdist_pkg::q30_t    slat2_s3, slon2_s3, cacb_s3;
	logic               v_s3;
	hdist_pkg::q30_t    slat2_s4, term_s4;
	logic               v_s4;
	logic [31:0]        a_sum;
	hdist_pkg::q30_t    a_s5;
	logic               v_s5;
	hdist_pkg::q30_t    one_minus_a;

	logic               sq_valid;
	hdist_pkg::q30_t    p_root, q_root;
	logic               vec_valid;
	logic [22:0]        z_ang;
	logic [54:0]        dist_prod;
	logic               done_q;
	logic [22:0]        distance_q;

	assign busy = 1'b0;

	// Clamp coordinates into range
	always_ff @(posedge clk) begin
		la_s1 <= (lat_a > hdist_pkg::LAT_MAX) ? hdist_pkg::LAT_MAX :
			(lat_a < hdist_pkg::LAT_MIN) ? hdist_pkg::LAT_MIN : lat_a;
		lb_s1 <= (lat_b > hdist_pkg::LAT_MAX) ? hdist_pkg::LAT_MAX :
			(lat_b < hdist_pkg::LAT_MIN) ? hdist_pkg::LAT_MIN : lat_b;
		oa_s1 <= (lon_a > hdist_pkg::LON_MAX) ? hdist_pkg::LON_MAX :
			(lon_a < hdist_pkg::LON_MIN) ? hdist_pkg::LON_MIN : lon_a;
		ob_s1 <= (lon_b > hdist_pkg::LON_MAX) ? hdist_pkg::LON_MAX :
			(lon_b < hdist_pkg::LON_MIN) ? hdist_pkg::LON_MIN : lon_b;
	end

	// Form half-angle magnitudes; fold the longitude half angle above 90 degrees
	assign dlat     = 25'(lb_s1) - 25'(la_s1);
	assign dlon     = 26'(ob_s1) - 26'(oa_s1);
	assign dlat_mag = dlat[24] ? 25'(-dlat) : 25'(dlat);
	assign dlon_mag = dlon[25] ? 26'(-dlon) : 26'(dlon);
	assign hlon_raw = dlon_mag[25:1];

	always_ff @(posedge clk) begin
		la_s2   <= la_s1;
		lb_s2   <= lb_s1;
		hlat_s2 <= dlat_mag[24:1];
		if (hlon_raw > {1'b0, hdist_pkg::DEG90_Q16})
			hlon_s2 <= 24'(hdist_pkg::DEG180_Q16 - hlon_raw);
		else
			hlon_s2 <= hlon_raw[23:0];
	end

	hdist_cordic_rot u_rot_lat (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s2),
		.ang($signed({2'b00, hlat_s2})),
		.out_valid(rot_valid), .cos_mag(unused_c0), .sin_mag(s_lat)
	);

	hdist_cordic_rot u_rot_lon (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s2),
		.ang($signed({2'b00, hlon_s2})),
		.out_valid(), .cos_mag(unused_c1), .sin_mag(s_lon)
	);

	hdist_cordic_rot u_rot_a (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s2),
		.ang(26'(la_s2)),
		.out_valid(), .cos_mag(c_a), .sin_mag(unused_s0)
	);

	hdist_cordic_rot u_rot_b (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s2),
		.ang(26'(lb_s2)),
		.out_valid(), .cos_mag(c_b), .sin_mag(unused_s1)
	);

	// Square the sines and multiply the cosines
	assign slat_sq = 62'(s_lat) * 62'(s_lat);
	assign slon_sq = 62'(s_lon) * 62'(s_lon);
	assign cacb    = 62'(c_a) * 62'(c_b);

	always_ff @(posedge clk) begin
		slat2_s3 <= slat_sq[60:30];
		slon2_s3 <= slon_sq[60:30];
		cacb_s3  <= cacb[60:30];
	end

	// Weight the longitude term by the cosine product
	assign term = 62'(cacb_s3) * 62'(slon2_s3);

	always_ff @(posedge clk) begin
		slat2_s4 <= slat2_s3;
		term_s4  <= term[60:30];
	end

	// Sum and clamp a to at most one
	assign a_sum = 32'(slat2_s4) + 32'(term_s4);

	always_ff @(posedge clk) begin
		a_s5 <= (a_sum > 32'(hdist_pkg::ONE_Q30)) ? hdist_pkg::ONE_Q30 : a_sum[30:0];
	end

	assign one_minus_a = hdist_pkg::ONE_Q30 - a_s5;

	hdist_isqrt u_sqrt_p (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s5),
		.arg({a_s5, 30'd0}),
		.out_valid(sq_valid), .root(p_root)
	);

	hdist_isqrt u_sqrt_q (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s5),
		.arg({one_minus_a, 30'd0}),
		.out_valid(), .root(q_root)
	);

	hdist_cordic_vec u_atan (
		.clk(clk), .arst_n(arst_n), .in_valid(sq_valid),
		.p(p_root), .q(q_root),
		.out_valid(vec_valid), .angle(z_ang)
	);

	// Scale the central angle to 1/256 km
	assign dist_prod = 55'({z_ang, 1'b0}) * 55'(hdist_pkg::DEG_TO_KM256_Q16);

	always_ff @(posedge clk) begin
		distance_q <= dist_prod[54:32];
	end

	// Advance valid bits through the local stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start & ~busy;
			v_s2   <= v_s1;
			v_s3   <= rot_valid;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			done_q <= vec_valid;
		end
	end

	assign done        = done_q;
	assign distance_km = distance_q;

endmodule

[rtl/hdist_checker.sv]
// Port-level checks on the haversine distance block, bound to the top level.
module hdist_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic signed [23:0] lat_a,
	input logic signed [24:0] lon_a,
	input logic signed [23:0] lat_b,
	input logic signed [24:0] lon_b,
	input logic               done,
	input logic [22:0]        distance_km
);

	// Never refuse a request
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// A result only follows an accepted request
	a_done_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 79))
		else $error("result without request");

	// Distance stays within half the circumference
	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (distance_km <= 23'd5123862))
		else $error("distance out of range");

	// Every strobed distance carries defined bits
	a_dist_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(distance_km))
		else $error("undefined distance on result");

endmodule

bind haversine_distance_top hdist_checker u_hdist_checker (.*);

[dv/haversine_distance_top_test.sv]
// Self-checking testbench for the haversine distance pipeline with its own fixed-point predictor.
module haversine_distance_top_test;

	localparam longint LAT_LIM   = 5898240;
	localparam longint LON_LIM   = 11796480;
	localparam longint Q30_ONE   = 1073741824;
	localparam longint INV_GAIN  = 652032875;
	localparam longint KM256_DEG = 1865538680;
	localparam int     IDLE_LIMIT = 5000;
	localparam int     DRAIN_CYCLES = 120;

	localparam longint ROT_ANGLE [20] = '{
		2949120, 1740967, 919879, 466945, 234379, 117266, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
	};

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [23:0] lat_a;
	logic signed [24:0] lon_a;
	logic signed [23:0] lat_b;
	logic signed [24:0] lon_b;
	logic               done;
	logic [22:0]        distance_km;

	logic [22:0] expected_distances [$];
	int          mismatches;
	int          requests_sent;
	int          distances_seen;
	int          idle_cycles;
	int          burst_left;

	haversine_distance_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.lat_a(lat_a),
		.lon_a(lon_a),
		.lat_b(lat_b),
		.lon_b(lon_b),
		.done(done),
		.distance_km(distance_km)
	);

	// Generate the clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// Rotate a unit vector by an angle in degrees Q16, giving Q30 cosine and sine magnitudes
	function automatic void rotate_unit(input longint ang, output longint c, output longint s);
		longint x, y, z, dx, dy;
		x = INV_GAIN;
		y = 0;
		z = ang;
		for (int i = 0; i < 20; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ROT_ANGLE[i];
			end else begin
				x += dx; y -= dy; z += ROT_ANGLE[i];
			end
		end
		if (y < 0)
			y = -y;
		c = clip(x, 0, Q30_ONE);
		s = clip(y, 0, Q30_ONE);
	endfunction

	// Angle of the vector (x, y) in degrees Q16, both components non-negative
	function automatic longint vector_angle(input longint yv, input longint xv);
		longint x, y, z, dx, dy;
		x = xv;
		y = yv;
		z = 0;
		for (int i = 0; i < 20; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += ROT_ANGLE[i];
			end else begin
				x -= dx; y += dy; z -= ROT_ANGLE[i];
			end
		end
		return clip(z, 0, LAT_LIM);
	endfunction

	function automatic longint unsigned floor_root(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint half_sine(input longint d);
		longint h, c, s;
		if (d < 0)
			d = -d;
		h = d >> 1;
		if (h > LAT_LIM)
			h = LON_LIM - h;
		rotate_unit(h, c, s);
		return s;
	endfunction

	function automatic longint q30_mul(input longint x, input longint y);
		return (x * y) >>> 30;
	endfunction

	// Great-circle distance in 1/256 km for one pair of points
	function automatic logic [22:0] great_circle(input longint la, input longint oa,
			input longint lb, input longint ob);
		longint sl, so, ca, cb, scratch, hav, p, q, z;
		longint unsigned km;
		la = clip(la, -LAT_LIM, LAT_LIM);
		oa = clip(oa, -LON_LIM, LON_LIM);
		lb = clip(lb, -LAT_LIM, LAT_LIM);
		ob = clip(ob, -LON_LIM, LON_LIM);
		sl = half_sine(lb - la);
		so = half_sine(ob - oa);
		rotate_unit(la, ca, scratch);
		rotate_unit(lb, cb, scratch);
		hav = q30_mul(sl, sl) + q30_mul(q30_mul(ca, cb), q30_mul(so, so));
		hav = clip(hav, 0, Q30_ONE);
		p = floor_root(hav << 30);
		q = floor_root((Q30_ONE - hav) << 30);
		z = vector_angle(p, q);
		km = ((2 * z) * KM256_DEG) >> 32;
		return km[22:0];
	endfunction

	// Predict on each accepted request, check each strobed distance, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (start && !busy)
				expected_distances.push_back(great_circle(lat_a, lon_a, lat_b, lon_b));
			if (done) begin
				distances_seen <= distances_seen + 1;
				if (expected_distances.size() == 0) begin
					$display("%0t: distance %0d with no request outstanding", $time,
						distance_km);
					mismatches <= mismatches + 1;
				end else begin
					if (distance_km !== expected_distances[0]) begin
						$display("%0t: distance_km expected %0d actual %0d", $time,
							expected_distances[0], distance_km);
						mismatches <= mismatches + 1;
					end
					void'(expected_distances.pop_front());
				end
			end
			if (idle_cycles > IDLE_LIMIT) begin
				$display("%0t: timeout, no request or distance for %0d cycles", $time,
					idle_cycles);
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Send one request, holding start high into the next one unless a gap is drawn
	task automatic send_points(input logic signed [23:0] la, input logic signed [24:0] oa,
			input logic signed [23:0] lb, input logic signed [24:0] ob);
		logic taken;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		lat_a <= la;
		lon_a <= oa;
		lat_b <= lb;
		lon_b <= ob;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		requests_sent++;
	endtask

	function automatic logic signed [23:0] any_lat();
		return $signed(24'($urandom_range(0, 32'(2 * LAT_LIM))) - 24'(LAT_LIM));
	endfunction

	function automatic logic signed [24:0] any_lon();
		return $signed(25'($urandom_range(0, 32'(2 * LON_LIM))) - 25'(LON_LIM));
	endfunction

	// Extremes, clamping, same point, poles and antipodes
	task automatic test_directed();
		send_points('0, '0, '0, '0);
		send_points(24'sd1234567, -25'sd7654321, 24'sd1234567, -25'sd7654321);
		send_points(hdist_pkg::LAT_MAX, '0, hdist_pkg::LAT_MIN, '0);
		send_points('0, hdist_pkg::LON_MIN, '0, hdist_pkg::LON_MAX);
		send_points('0, '0, '0, hdist_pkg::LON_MAX);
		send_points('0, hdist_pkg::LON_MIN, '0, '0);
		send_points(hdist_pkg::LAT_MAX, hdist_pkg::LON_MIN, hdist_pkg::LAT_MIN,
			hdist_pkg::LON_MAX);
		send_points(hdist_pkg::LAT_MAX, '0, hdist_pkg::LAT_MAX, hdist_pkg::LON_MAX);
		send_points(24'sh7FFFFF, 25'sh0FFFFFF, 24'sh800000, 25'sh1000000);
		send_points(24'sh800000, 25'sh1000000, 24'sh7FFFFF, 25'sh0FFFFFF);
		send_points(24'sh7FFFFF, '0, hdist_pkg::LAT_MAX, '0);
		send_points('0, 25'sh1000000, '0, hdist_pkg::LON_MIN);
		send_points('0, '0, '0, 25'sd1);
		send_points('0, '0, 24'sd1, '0);
		send_points(-24'sd1, -25'sd1, 24'sd1, 25'sd1);
		send_points('0, '0, hdist_pkg::LAT_MAX, '0);
		send_points('0, -25'sd5898240, '0, 25'sd5898240);
		send_points(24'sd2949120, 25'sd2949120, -24'sd2949120, -25'sd8847360);
		send_points(24'shFFFFFF, 25'sh1FFFFFF, '0, '0);
		send_points(24'sh555555, 25'sh0AAAAAA, 24'shAAAAAA, 25'sh1555555);
	endtask

	// Points anywhere on the globe
	task automatic test_random_globe(input int n);
		repeat (n) send_points(any_lat(), any_lon(), any_lat(), any_lon());
	endtask

	// Nearby points, where the small-angle end of the chain matters
	task automatic test_random_nearby(input int n);
		logic signed [23:0] la;
		logic signed [24:0] oa;
		repeat (n) begin
			la = any_lat();
			oa = any_lon();
			send_points(la, oa, la + 24'($signed($urandom_range(0, 8192)) - 4096),
				oa + 25'($signed($urandom_range(0, 8192)) - 4096));
		end
	endtask

	// Raw bit patterns, partly out of range and clamped
	task automatic test_random_raw(input int n);
		repeat (n) send_points(24'($urandom), 25'($urandom), 24'($urandom), 25'($urandom));
	endtask

	initial begin
		start = 1'b0;
		lat_a = '0;
		lon_a = '0;
		lat_b = '0;
		lon_b = '0;
		mismatches = 0;
		requests_sent = 0;
		distances_seen = 0;
		idle_cycles = 0;
		burst_left = 0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_globe(700);
		test_random_nearby(250);
		test_random_raw(180);
		start <= 1'b0;

		// Drain the pipeline, then watch for stray strobes
		while (expected_distances.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d point pairs: directed extremes, globe-wide, nearby and raw patterns.",
			requests_sent);
		$display("Checked %0d distances with %0d mismatches.", distances_seen, mismatches);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[filelist.f]
rtl/hdist_pkg.sv
rtl/hdist_cordic_rot.sv
rtl/hdist_isqrt.sv
rtl/hdist_cordic_vec.sv
rtl/haversine_distance_top.sv
rtl/hdist_checker.sv
dv/haversine_distance_top_test.sv
